FILE: src/bezier_surface_point_eval_defines.svh
// ---------------------------------------------------------------------------
// Bezier surface evaluator assertion macros
// Concurrent assertion wrappers; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef BEZIER_SURFACE_POINT_EVAL_DEFINES_SVH
`define BEZIER_SURFACE_POINT_EVAL_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define BZS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bzs assertion failed");
// Expression must never be true outside reset
`define BZS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `BZS_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define BZS_ASSERT(lbl, clk, rst_n, prop)
`define BZS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: src/bzs_pkg.sv
// ---------------------------------------------------------------------------
// Bezier surface evaluator package
// Shared types, codes, constants and the binomial table.
// ---------------------------------------------------------------------------
package bzs_pkg;

    localparam int MAX_ORDER_DEF  = 8;
    localparam int COORD_BITS_DEF = 32;
    localparam int WFRAC          = 16;
    localparam int DIV_STEPS      = 18;
    localparam int WGT_W          = 17;
    localparam int NUM_W          = 64;

    // configuration register indexes
    localparam logic [1:0] CFG_DEG_ROWS = 2'd0;
    localparam logic [1:0] CFG_DEG_COLS = 2'd1;
    localparam logic [1:0] CFG_RES      = 2'd2;

    // item kinds carried in tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic [2:0] RST_DEG = 3'd3;
    localparam logic [7:0] RST_RES = 8'd16;

    localparam logic [5:0] BINOM [8][8] = '{
        '{6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
        '{6'd1, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
        '{6'd1, 6'd2, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
        '{6'd1, 6'd3, 6'd3, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0},
        '{6'd1, 6'd4, 6'd6, 6'd4, 6'd1, 6'd0, 6'd0, 6'd0},
        '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5, 6'd1, 6'd0, 6'd0},
        '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6, 6'd1, 6'd0},
        '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_WI,
        S_WJ,
        S_MW,
        S_MAC,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        W_IDLE,
        W_MUL,
        W_DIV
    } t_wstate;

    // one Bernstein weight request
    typedef struct packed {
        logic [2:0] d;
        logic [2:0] k;
        logic [7:0] n;
        logic [7:0] r;
    } t_wreq;

endpackage

FILE: src/bezier_surface_point_eval.sv
// Load beat: written to the control store in the accepting cycle, ready again next cycle.
// Evaluate beat: the shared weight divider (18 steps per weight) forms the row and then the
// column weights, and the single multiply-accumulate (one coordinate per cycle in S_MAC, after
// an S_MW weight product for each point) sums the control points into the result on o_m_tvalid.
// One item at a time; a new beat is taken while a result waits in the output register.
// Reset (synchronous, active low) restores degrees 3/3, resolution 16; the store is not cleared.
// ---------------------------------------------------------------------------
// Bezier surface point evaluator
// Tensor-product Bezier surface evaluation over a 64-entry control store.
// ---------------------------------------------------------------------------
`include "bezier_surface_point_eval_defines.svh"

module bezier_surface_point_eval #(
    parameter int MAX_ORDER  = bzs_pkg::MAX_ORDER_DEF,
    parameter int COORD_BITS = bzs_pkg::COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // point_index[5:0], in_x[37:6], in_y[69:38], in_z[101:70],
    // s_step[109:102], t_step[117:110], zero pad[119:118]
    input  logic [119:0] i_s_tdata,
    // mode[0]
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  o_m_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    localparam int CW    = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int ORD   = (MAX_ORDER < 8) ? MAX_ORDER : 8;
    localparam int IW    = $clog2(ORD);
    localparam int LIM   = ORD - 1;
    localparam int ACC_W = CW + 20;
    localparam int WW    = bzs_pkg::WGT_W;
    localparam logic signed [ACC_W-16:0] SAT_HI =
        (ACC_W - 15)'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [ACC_W-16:0] SAT_LO = ~SAT_HI;

    bzs_pkg::t_state          r_state, n_state;
    logic                     r_issued, n_issued;
    logic [IW-1:0]            r_k, n_k;
    logic [IW-1:0]            r_i, n_i;
    logic [IW-1:0]            r_j, n_j;
    logic [1:0]               r_c, n_c;
    logic [IW-1:0]            r_dm, r_dn;
    logic [7:0]               r_s, r_t, r_rs;
    logic [2:0]               r_deg_rows, r_deg_cols;
    logic [7:0]               r_res;
    logic [WW-1:0]            r_wi [ORD];
    logic [WW-1:0]            r_wj [ORD];
    logic [WW-1:0]            r_w;
    logic signed [ACC_W-1:0]  r_acc [3];
    logic                     r_out_valid, n_out_valid;
    logic [95:0]              r_out_data;
    logic [3*CW-1:0]          mem [64];
    logic [3*CW-1:0]          r_rd;

    logic                     in_acc;
    logic                     do_load;
    logic                     do_eval;
    logic [7:0]               res_c, s_c, t_c;
    logic [IW-1:0]            dm_c, dn_c;
    logic                     w_start;
    bzs_pkg::t_wreq           w_req;
    logic                     w_done;
    logic [WW-1:0]            w_weight;
    logic [2*WW-1:0]          wprod;
    logic [5:0]               rd_addr;
    logic signed [CW-1:0]     p_sel;
    logic signed [CW+17:0]    mprod;
    logic [95:0]              fin;
    logic                     fin_go;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == bzs_pkg::S_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign do_load     = in_acc && (i_s_tuser == bzs_pkg::MODE_LOAD);
    assign do_eval     = in_acc && (i_s_tuser == bzs_pkg::MODE_EVAL);

    // clamp resolution, samples and degrees
    assign res_c = (r_res == 8'd0) ? 8'd1 : r_res;
    assign s_c   = (i_s_tdata[109:102] > res_c) ? res_c : i_s_tdata[109:102];
    assign t_c   = (i_s_tdata[117:110] > res_c) ? res_c : i_s_tdata[117:110];
    assign dm_c  = (r_deg_rows > 3'(LIM)) ? IW'(LIM) : IW'(r_deg_rows);
    assign dn_c  = (r_deg_cols > 3'(LIM)) ? IW'(LIM) : IW'(r_deg_cols);

    // weight requests for either direction
    always_comb begin
        w_req.k = 3'(r_k);
        w_req.r = r_rs;
        if (r_state == bzs_pkg::S_WJ) begin
            w_req.d = 3'(r_dn);
            w_req.n = r_t;
        end else begin
            w_req.d = 3'(r_dm);
            w_req.n = r_s;
        end
    end

    assign w_start = ((r_state == bzs_pkg::S_WI) || (r_state == bzs_pkg::S_WJ)) && !r_issued;

    bzs_weight u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_req    (w_req),
        .o_done   (w_done),
        .o_weight (w_weight)
    );

    // combined weight and multiply-accumulate operands
    assign wprod   = r_wi[r_i] * r_wj[r_j];
    assign rd_addr = {3'(r_i), 3'(r_j)};
    assign p_sel   = r_rd[r_c*CW +: CW];
    assign mprod   = p_sel * $signed({1'b0, r_w});
    assign fin_go  = (r_state == bzs_pkg::S_FIN) && (!r_out_valid || i_m_tready);

    // round half up and saturate each coordinate
    always_comb begin
        logic signed [ACC_W:0]    v;
        logic signed [ACC_W-16:0] q;
        logic signed [ACC_W-16:0] sq;
        logic signed [CW-1:0]     tc;
        fin = '0;
        for (int c = 0; c < 3; c++) begin
            v  = (ACC_W + 1)'(r_acc[c]) + (ACC_W + 1)'(1 << (bzs_pkg::WFRAC - 1));
            q  = v[ACC_W:16];
            sq = (q > SAT_HI) ? SAT_HI : ((q < SAT_LO) ? SAT_LO : q);
            tc = sq[CW-1:0];
            fin[c*32 +: 32] = 32'(tc);
        end
    end

    // sequence weights, products and output
    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_c         = r_c;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            bzs_pkg::S_IDLE: begin
                if (do_eval) begin
                    n_state  = bzs_pkg::S_WI;
                    n_issued = 1'b0;
                    n_k      = '0;
                end
            end
            bzs_pkg::S_WI: begin
                n_issued = 1'b1;
                if (w_done) begin
                    n_issued = 1'b0;
                    if (r_k == r_dm) begin
                        n_k     = '0;
                        n_state = bzs_pkg::S_WJ;
                    end else begin
                        n_k = r_k + IW'(1);
                    end
                end
            end
            bzs_pkg::S_WJ: begin
                n_issued = 1'b1;
                if (w_done) begin
                    n_issued = 1'b0;
                    if (r_k == r_dn) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = bzs_pkg::S_MW;
                    end else begin
                        n_k = r_k + IW'(1);
                    end
                end
            end
            bzs_pkg::S_MW: begin
                n_c     = 2'd0;
                n_state = bzs_pkg::S_MAC;
            end
            bzs_pkg::S_MAC: begin
                n_c = r_c + 2'd1;
                if (r_c == 2'd2) begin
                    n_state = bzs_pkg::S_MW;
                    if (r_j == r_dn) begin
                        n_j = '0;
                        if (r_i == r_dm) begin
                            n_state = bzs_pkg::S_FIN;
                        end else begin
                            n_i = r_i + IW'(1);
                        end
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end
            end
            bzs_pkg::S_FIN: begin
                if (fin_go) begin
                    n_out_valid = 1'b1;
                    n_state     = bzs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bzs_pkg::S_IDLE;
            end
        endcase
    end

    // hold control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bzs_pkg::S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_deg_rows  <= bzs_pkg::RST_DEG;
            r_deg_cols  <= bzs_pkg::RST_DEG;
            r_res       <= bzs_pkg::RST_RES;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bzs_pkg::CFG_DEG_ROWS: r_deg_rows <= i_cfg_data[2:0];
                    bzs_pkg::CFG_DEG_COLS: r_deg_cols <= i_cfg_data[2:0];
                    bzs_pkg::CFG_RES:      r_res      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // advance counters and datapath
    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_i <= n_i;
        r_j <= n_j;
        r_c <= n_c;
        if (do_eval) begin
            r_s  <= s_c;
            r_t  <= t_c;
            r_rs <= res_c;
            r_dm <= dm_c;
            r_dn <= dn_c;
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
            end
        end
        if (w_done && (r_state == bzs_pkg::S_WI)) begin
            r_wi[r_k] <= w_weight;
        end
        if (w_done && (r_state == bzs_pkg::S_WJ)) begin
            r_wj[r_k] <= w_weight;
        end
        if (r_state == bzs_pkg::S_MW) begin
            r_w <= WW'((wprod + (2*WW)'(1 << (bzs_pkg::WFRAC - 1))) >> bzs_pkg::WFRAC);
        end
        if (r_state == bzs_pkg::S_MAC) begin
            r_acc[r_c] <= r_acc[r_c] + ACC_W'(mprod);
        end
        if (fin_go) begin
            r_out_data <= fin;
        end
    end

    // control store: write on load beats, registered read
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            mem[i_s_tdata[5:0]] <= {i_s_tdata[70 +: CW], i_s_tdata[38 +: CW], i_s_tdata[6 +: CW]};
        end
        r_rd <= mem[rd_addr];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `BZS_ASSERT(a_eval_starts, i_clk, i_rst_n, do_eval |=> (r_state == bzs_pkg::S_WI))
    `BZS_ASSERT_NEVER(a_done_in_wstate, i_clk, i_rst_n,
        w_done && !((r_state == bzs_pkg::S_WI) || (r_state == bzs_pkg::S_WJ)))
    `BZS_ASSERT(a_fin_waits, i_clk, i_rst_n,
        ((r_state == bzs_pkg::S_FIN) && r_out_valid && !i_m_tready) |=> (r_state == bzs_pkg::S_FIN))

endmodule

FILE: src/bzs_weight.sv
// ---------------------------------------------------------------------------
// Bernstein weight unit
// Builds C(d,k) n^k (r-n)^(d-k) and r^d by repeated multiply, then divides
// them with a restoring divider, one quotient bit per cycle, rounded to Q1.16.
// ---------------------------------------------------------------------------
module bzs_weight (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  bzs_pkg::t_wreq                    i_req,
    output logic                              o_done,
    output logic [bzs_pkg::WGT_W-1:0]         o_weight
);

    bzs_pkg::t_wstate                  r_state, n_state;
    bzs_pkg::t_wreq                    r_req, n_req;
    logic [bzs_pkg::NUM_W-1:0]         r_num, n_num;
    logic [bzs_pkg::NUM_W-1:0]         r_den, n_den;
    logic [bzs_pkg::NUM_W-1:0]         r_rem, n_rem;
    logic [bzs_pkg::DIV_STEPS-1:0]     r_q, n_q;
    logic [2:0]                        r_f, n_f;
    logic [4:0]                        r_cnt, n_cnt;
    logic                              r_done, n_done;
    logic [bzs_pkg::WGT_W-1:0]         r_weight, n_weight;
    logic [7:0]                        factor;
    logic [bzs_pkg::NUM_W-1:0]         rem_sh;
    logic                              qbit;

    // factor n for the first k steps, r-n after
    assign factor = (r_f < r_req.k) ? r_req.n : (r_req.r - r_req.n);

    // sequence multiply and divide steps
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_num    = r_num;
        n_den    = r_den;
        n_rem    = r_rem;
        n_q      = r_q;
        n_f      = r_f;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_weight = r_weight;
        rem_sh   = (r_cnt == 5'd0) ? r_rem : {r_rem[bzs_pkg::NUM_W-2:0], 1'b0};
        qbit     = (rem_sh >= r_den);
        case (r_state)
            bzs_pkg::W_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_num   = bzs_pkg::NUM_W'(bzs_pkg::BINOM[i_req.d][i_req.k]);
                    n_den   = bzs_pkg::NUM_W'(1);
                    n_f     = 3'd0;
                    n_state = bzs_pkg::W_MUL;
                end
            end
            bzs_pkg::W_MUL: begin
                if (r_f == r_req.d) begin
                    n_rem   = r_num;
                    n_q     = '0;
                    n_cnt   = 5'd0;
                    n_state = bzs_pkg::W_DIV;
                end else begin
                    n_num = r_num * bzs_pkg::NUM_W'(factor);
                    n_den = r_den * bzs_pkg::NUM_W'(r_req.r);
                    n_f   = r_f + 3'd1;
                end
            end
            bzs_pkg::W_DIV: begin
                n_rem = qbit ? (rem_sh - r_den) : rem_sh;
                n_q   = {r_q[bzs_pkg::DIV_STEPS-2:0], qbit};
                if (r_cnt == 5'(bzs_pkg::DIV_STEPS - 1)) begin
                    n_weight = bzs_pkg::WGT_W'(
                        ({1'b0, n_q} + (bzs_pkg::DIV_STEPS + 1)'(1)) >> 1);
                    n_done   = 1'b1;
                    n_state  = bzs_pkg::W_IDLE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            default: begin
                n_state = bzs_pkg::W_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bzs_pkg::W_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // hold datapath
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_f      <= n_f;
        r_cnt    <= n_cnt;
        r_weight <= n_weight;
    end

    assign o_done   = r_done;
    assign o_weight = r_weight;

endmodule
